>>> hdl/obrnh_pkg.sv
// ----------------------------------------------------------------------------
// obrnh_pkg
// Shared types, register codes, widths and fixed-point helpers of the
// oriented box ray nearest-hit unit.
// ----------------------------------------------------------------------------
`default_nettype none

package obrnh_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 3'd6;

  // Defaults for top-level parameters
  localparam int MAX_BOXES_DEF   = 4096;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Field widths
  localparam int POSN_W = 32;   // Q16.16 positions
  localparam int DIR_W  = 16;   // Q2.14
  localparam int DIST_W = 31;   // unsigned Q15.16
  localparam int IDX_W  = 12;   // reported index
  localparam int POS_W  = 16;   // stream position carried through the queue
  localparam int OFF_W  = 33;   // origin minus center
  localparam int QA_W   = 17;   // negated quaternion component
  localparam int VEC_W  = 40;   // rotation operand / cross term
  localparam int PRD_W  = QA_W + VEC_W;
  localparam int LOC_W  = 42;   // rotated vector component
  localparam int NUM_W  = 56;   // slab numerator magnitude
  localparam int DEN_W  = 24;   // local direction magnitude

  localparam logic [DIR_W-1:0]  DIR_X_RST    = 16'd16384;
  localparam logic [DIST_W-1:0] MAX_DIST_RST = 31'd4194304;

  typedef struct packed {
    logic signed [POSN_W-1:0] org_x;
    logic signed [POSN_W-1:0] org_y;
    logic signed [POSN_W-1:0] org_z;
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic signed [DIR_W-1:0]  dir_z;
    logic [DIST_W-1:0]        max_dist;
  } ray_cfg_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;
    logic signed [OFF_W-1:0] off_z;
    logic signed [DIR_W-1:0] rot_x;
    logic signed [DIR_W-1:0] rot_y;
    logic signed [DIR_W-1:0] rot_z;
    logic signed [DIR_W-1:0] rot_w;
    logic [DIST_W-1:0]       half_x;
    logic [DIST_W-1:0]       half_y;
    logic [DIST_W-1:0]       half_z;
    logic                    test;   // box goes through the slab test
    logic                    last;
    logic                    first;  // opens a new search
    logic [POS_W-1:0]        pos;
  } box_item_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] hit_dist;
  } result_t;

  // Signed 17 x 40 product
  function automatic logic signed [PRD_W-1:0] mul_qv(input logic signed [QA_W-1:0] a,
                                                     input logic signed [VEC_W-1:0] b);
    return a * b;
  endfunction

  // Divide by 2^14, round to nearest, ties away from zero
  function automatic logic signed [63:0] round14(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? (64'd0 - 64'(x)) : 64'(x);
    r   = (mag + 64'd8192) >> 14;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

`default_nettype wire

>>> hdl/obrnh_front.sv
// ----------------------------------------------------------------------------
// obrnh_front
// Accepts box beats, computes the origin offset, classifies the box and
// tags it with its stream position before it enters the work queue.
// ----------------------------------------------------------------------------
`default_nettype none

module obrnh_front
  import obrnh_pkg::*;
#(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire ray_cfg_t                 ray,
  input  wire logic                     push,
  input  wire logic signed [POSN_W-1:0] center_x,
  input  wire logic signed [POSN_W-1:0] center_y,
  input  wire logic signed [POSN_W-1:0] center_z,
  input  wire logic signed [DIR_W-1:0]  rot_x,
  input  wire logic signed [DIR_W-1:0]  rot_y,
  input  wire logic signed [DIR_W-1:0]  rot_z,
  input  wire logic signed [DIR_W-1:0]  rot_w,
  input  wire logic [DIST_W-1:0]        half_x,
  input  wire logic [DIST_W-1:0]        half_y,
  input  wire logic [DIST_W-1:0]        half_z,
  input  wire logic                     skip,
  input  wire logic                     last,
  input  wire logic                     q_full,
  output logic                          q_wr,
  output box_item_t                     q_data
);

  localparam int CNT_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_BOXES - 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign q_wr = push && !q_full;

  // Build the queue entry
  always_comb begin
    q_data.off_x  = OFF_W'(ray.org_x) - OFF_W'(center_x);
    q_data.off_y  = OFF_W'(ray.org_y) - OFF_W'(center_y);
    q_data.off_z  = OFF_W'(ray.org_z) - OFF_W'(center_z);
    q_data.rot_x  = rot_x;
    q_data.rot_y  = rot_y;
    q_data.rot_z  = rot_z;
    q_data.rot_w  = rot_w;
    q_data.half_x = half_x;
    q_data.half_y = half_y;
    q_data.half_z = half_z;
    q_data.test   = !skip && (ray.max_dist != '0);
    q_data.last   = last;
    q_data.first  = (cnt_r == '0);
    q_data.pos    = POS_W'(cnt_r);
  end

  // Stream position: saturates, restarts after the last box
  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr) begin
      if (last) begin
        cnt_nxt = '0;
      end else if (cnt_r < CNT_SAT) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/obrnh_fifo.sv
// ----------------------------------------------------------------------------
// obrnh_fifo
// Short work queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module obrnh_fifo
  import obrnh_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr,
  input  wire box_item_t wdata,
  output logic           full,
  input  wire logic      rd,
  output box_item_t      rdata,
  output logic           empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] DEPTH_C = (AW + 1)'(DEPTH);

  box_item_t     slot_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == DEPTH_C);
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wp_r] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/obrnh_div.sv
// ----------------------------------------------------------------------------
// obrnh_div
// Signed divider, quotient truncated toward zero, two quotient bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module obrnh_div
  import obrnh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             num_neg,
  input  wire logic [NUM_W-1:0] num_mag,
  input  wire logic             den_neg,
  input  wire logic [DEN_W-1:0] den_mag,
  output logic                  done,
  output logic signed [63:0]    quo
);

  localparam int STEPS = NUM_W / 2;
  localparam int SC_W  = $clog2(STEPS);
  localparam logic [SC_W-1:0] LAST_STEP = SC_W'(STEPS - 1);

  logic             busy_r;
  logic [SC_W-1:0]  step_r;
  logic             neg_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   rem_nxt;
  logic [NUM_W-1:0] quo_nxt;

  // Two restoring steps
  always_comb begin
    logic [DEN_W:0] sh;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < 2; i++) begin
      sh      = {rem_nxt[DEN_W-1:0], quo_nxt[NUM_W-1]};
      quo_nxt = {quo_nxt[NUM_W-2:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        rem_nxt    = sh - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = sh;
      end
    end
  end

  assign done = busy_r && (step_r == LAST_STEP);
  assign quo  = neg_r ? -$signed(64'(quo_nxt)) : $signed(64'(quo_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= '0;
      neg_r  <= num_neg ^ den_neg;
      den_r  <= den_mag;
      rem_r  <= '0;
      quo_r  <= num_mag;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/obrnh_back.sv
// ----------------------------------------------------------------------------
// obrnh_back
// Works one box at a time: two quaternion rotations on a shared set of
// multipliers, then a three-axis slab test, then the nearest-hit update.
// ----------------------------------------------------------------------------
`default_nettype none

module obrnh_back
  import obrnh_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire ray_cfg_t  ray,
  input  wire logic      q_empty,
  input  wire box_item_t q_data,
  output logic           q_rd,
  input  wire logic      res_ready,
  output logic           res_valid,
  output result_t        res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CROSS = 3'd1;
  localparam logic [2:0] ST_ROT   = 3'd2;
  localparam logic [2:0] ST_SLAB  = 3'd3;
  localparam logic [2:0] ST_DIVN  = 3'd4;
  localparam logic [2:0] ST_DIVF  = 3'd5;
  localparam logic [2:0] ST_CMP   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]              state_r;
  box_item_t               box_r;
  logic                    vsel_r;   // 0: origin offset, 1: direction
  logic [1:0]              k_r;      // component / axis
  logic signed [VEC_W-1:0] vec_r [3];
  logic signed [VEC_W-1:0] dv_r  [3];
  logic signed [LOC_W-1:0] lo_r  [3];
  logic signed [LOC_W-1:0] ld_r  [3];
  logic signed [63:0]      entry_r;
  logic signed [63:0]      exit_r;
  logic signed [63:0]      tn_r;
  logic signed [63:0]      tf_r;
  logic                    miss_r;
  logic [DIST_W-1:0]       near_r;
  logic                    any_r;
  logic [POS_W-1:0]        npos_r;

  logic signed [QA_W-1:0]  ax, ay, az, aw;
  logic signed [PRD_W-1:0] p0, p1, p2;
  logic signed [VEC_W-1:0] vk;
  logic signed [63:0]      cross_d;
  logic signed [63:0]      rot_o;
  logic signed [63:0]      so, sd, sh, num;
  logic                    par_miss;
  logic                    div_start, div_done;
  logic signed [63:0]      div_q;
  logic signed [63:0]      t_lo, t_hi, ent, ext;
  logic                    upd;
  logic [DIST_W-1:0]       near_new;
  logic                    any_new;
  logic [POS_W-1:0]        npos_new;

  // Conjugate quaternion
  assign ax = -QA_W'(box_r.rot_x);
  assign ay = -QA_W'(box_r.rot_y);
  assign az = -QA_W'(box_r.rot_z);
  assign aw = QA_W'(box_r.rot_w);

  // Shared multipliers: cross term in CROSS, rotated sum in ROT
  always_comb begin
    p0 = '0;
    p1 = '0;
    p2 = '0;
    vk = '0;
    if (state_r == ST_CROSS) begin
      case (k_r)
        2'd0: begin p1 = mul_qv(ay, vec_r[2]); p2 = mul_qv(az, vec_r[1]); end
        2'd1: begin p1 = mul_qv(az, vec_r[0]); p2 = mul_qv(ax, vec_r[2]); end
        2'd2: begin p1 = mul_qv(ax, vec_r[1]); p2 = mul_qv(ay, vec_r[0]); end
        default: begin p1 = '0; p2 = '0; end
      endcase
    end else begin
      case (k_r)
        2'd0: begin
          p0 = mul_qv(aw, dv_r[0]); p1 = mul_qv(ay, dv_r[2]);
          p2 = mul_qv(az, dv_r[1]); vk = vec_r[0];
        end
        2'd1: begin
          p0 = mul_qv(aw, dv_r[1]); p1 = mul_qv(az, dv_r[0]);
          p2 = mul_qv(ax, dv_r[2]); vk = vec_r[1];
        end
        2'd2: begin
          p0 = mul_qv(aw, dv_r[2]); p1 = mul_qv(ax, dv_r[1]);
          p2 = mul_qv(ay, dv_r[0]); vk = vec_r[2];
        end
        default: begin p0 = '0; p1 = '0; p2 = '0; vk = '0; end
      endcase
    end
  end

  always_comb begin
    logic signed [63:0] s;
    s       = 64'(p1) - 64'(p2);
    cross_d = round14(s <<< 1);
    rot_o   = 64'(vk) + round14(64'(p0) + 64'(p1) - 64'(p2));
  end

  // Slab operands of the current axis
  always_comb begin
    case (k_r)
      2'd0: begin so = 64'(lo_r[0]); sd = 64'(ld_r[0]); sh = $signed(64'(box_r.half_x)); end
      2'd1: begin so = 64'(lo_r[1]); sd = 64'(ld_r[1]); sh = $signed(64'(box_r.half_y)); end
      2'd2: begin so = 64'(lo_r[2]); sd = 64'(ld_r[2]); sh = $signed(64'(box_r.half_z)); end
      default: begin so = '0; sd = '0; sh = '0; end
    endcase
    par_miss = (so < -sh) || (so > sh);
    num      = (state_r == ST_SLAB) ? ((-sh - so) <<< 14) : ((sh - so) <<< 14);
  end

  assign div_start = ((state_r == ST_SLAB) && (sd != '0)) ||
                     ((state_r == ST_DIVN) && div_done);

  obrnh_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_neg (num[63]),
    .num_mag (num[63] ? NUM_W'(-num) : NUM_W'(num)),
    .den_neg (sd[63]),
    .den_mag (sd[63] ? DEN_W'(-sd) : DEN_W'(sd)),
    .done    (div_done),
    .quo     (div_q)
  );

  // Interval update from the near and far plane distances
  always_comb begin
    t_lo = (tn_r < tf_r) ? tn_r : tf_r;
    t_hi = (tn_r < tf_r) ? tf_r : tn_r;
    ent  = (t_lo > entry_r) ? t_lo : entry_r;
    ext  = (t_hi < exit_r) ? t_hi : exit_r;
  end

  // Nearest-hit update at the end of a box
  always_comb begin
    upd      = box_r.test && !miss_r &&
               (!any_r || (entry_r < $signed(64'(near_r))));
    near_new = upd ? DIST_W'(entry_r) : near_r;
    any_new  = any_r || upd;
    npos_new = upd ? box_r.pos : npos_r;
  end

  assign q_rd         = (state_r == ST_IDLE) && !q_empty;
  assign res_valid    = (state_r == ST_FIN) && box_r.last && res_ready;
  assign res.hit      = any_new;
  assign res.idx      = any_new ? IDX_W'(npos_new) : '0;
  assign res.hit_dist = any_new ? near_new : '0;

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      near_r  <= MAX_DIST_RST;
      any_r   <= 1'b0;
      npos_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_data.first) begin
              near_r <= ray.max_dist;
              any_r  <= 1'b0;
              npos_r <= '0;
            end
            state_r <= q_data.test ? ST_CROSS : ST_FIN;
          end
        end
        ST_CROSS: begin
          if (k_r == 2'd2) begin
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (k_r == 2'd2) begin
            state_r <= vsel_r ? ST_SLAB : ST_CROSS;
          end
        end
        ST_SLAB: begin
          if (sd != '0) begin
            state_r <= ST_DIVN;
          end else if (par_miss || (k_r == 2'd2)) begin
            state_r <= ST_FIN;
          end
        end
        ST_DIVN: begin
          if (div_done) begin
            state_r <= ST_DIVF;
          end
        end
        ST_DIVF: begin
          if (div_done) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ((ent > ext) || (k_r == 2'd2)) ? ST_FIN : ST_SLAB;
        end
        ST_FIN: begin
          if (!box_r.last) begin
            near_r  <= near_new;
            any_r   <= any_new;
            npos_r  <= npos_new;
            state_r <= ST_IDLE;
          end else if (res_ready) begin
            near_r  <= ray.max_dist;
            any_r   <= 1'b0;
            npos_r  <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        box_r    <= q_data;
        miss_r   <= 1'b0;
        vsel_r   <= 1'b0;
        k_r      <= 2'd0;
        vec_r[0] <= VEC_W'(q_data.off_x);
        vec_r[1] <= VEC_W'(q_data.off_y);
        vec_r[2] <= VEC_W'(q_data.off_z);
      end
      ST_CROSS: begin
        dv_r[k_r] <= VEC_W'(cross_d);
        k_r       <= (k_r == 2'd2) ? 2'd0 : k_r + 1'b1;
      end
      ST_ROT: begin
        if (vsel_r) begin
          ld_r[k_r] <= LOC_W'(rot_o);
        end else begin
          lo_r[k_r] <= LOC_W'(rot_o);
        end
        k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 1'b1;
        if (k_r == 2'd2) begin
          vsel_r   <= 1'b1;
          vec_r[0] <= VEC_W'(ray.dir_x);
          vec_r[1] <= VEC_W'(ray.dir_y);
          vec_r[2] <= VEC_W'(ray.dir_z);
          entry_r  <= '0;
          exit_r   <= $signed(64'(near_r));
        end
      end
      ST_SLAB: begin
        if (sd == '0) begin
          if (par_miss) begin
            miss_r <= 1'b1;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
      end
      ST_DIVN: begin
        if (div_done) begin
          tn_r <= div_q;
        end
      end
      ST_DIVF: begin
        if (div_done) begin
          tf_r <= div_q;
        end
      end
      ST_CMP: begin
        if (ent > ext) begin
          miss_r <= 1'b1;
        end else begin
          entry_r <= ent;
          exit_r  <= ext;
          k_r     <= k_r + 1'b1;
        end
      end
      default: begin
        k_r <= k_r;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/oriented_box_ray_nearest_hit_unit.sv
// ----------------------------------------------------------------------------
// oriented_box_ray_nearest_hit_unit
// Tests one ray against a stream of oriented boxes and reports the nearest
// hit after the last box of each stream.
// ----------------------------------------------------------------------------
//  channel  | ports                        | beat
//  ---------+------------------------------+-----------------------------------
//  input    | in_push / in_full            | one box
//  result   | out_empty / out_pop          | hit, index, distance (last box)
//  config   | cfg_we, cfg_index, cfg_wdata | one register write
//
//  A skipped box goes through fetch and finish in the back part; a tested box
//  goes through fetch, rotation and finish, plus a slab step per parallel axis
//  or two divisions per non-parallel axis in the slab divider (two quotient
//  bits a cycle).
//  Synchronous reset clears the queues and the search; no clearing pass.
//  A two-entry queue lets the front accept boxes while the back is busy;
//  a full result register stalls the back only on a last box.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_box_ray_nearest_hit_unit
  import obrnh_pkg::*;
#(
  parameter int MAX_BOXES   = MAX_BOXES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic signed [POSN_W-1:0] in_box_center_x,
  input  wire logic signed [POSN_W-1:0] in_box_center_y,
  input  wire logic signed [POSN_W-1:0] in_box_center_z,
  input  wire logic signed [DIR_W-1:0]  in_rot_x,
  input  wire logic signed [DIR_W-1:0]  in_rot_y,
  input  wire logic signed [DIR_W-1:0]  in_rot_z,
  input  wire logic signed [DIR_W-1:0]  in_rot_w,
  input  wire logic [DIST_W-1:0]        in_half_size_x,
  input  wire logic [DIST_W-1:0]        in_half_size_y,
  input  wire logic [DIST_W-1:0]        in_half_size_z,
  input  wire logic                     in_skip_box,
  input  wire logic                     in_last_box,
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic                          out_hit,
  output logic [IDX_W-1:0]              out_hit_index,
  output logic [DIST_W-1:0]             out_hit_distance,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [POSN_W-1:0]        cfg_wdata
);

  ray_cfg_t  ray_r;
  logic      q_wr, q_full, q_rd, q_empty;
  box_item_t q_wdata, q_rdata;
  logic      res_valid;
  result_t   res;
  logic      out_valid_r;
  result_t   out_r;

  // Ray registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.org_x    <= '0;
      ray_r.org_y    <= '0;
      ray_r.org_z    <= '0;
      ray_r.dir_x    <= DIR_X_RST;
      ray_r.dir_y    <= '0;
      ray_r.dir_z    <= '0;
      ray_r.max_dist <= MAX_DIST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: ray_r.org_x    <= cfg_wdata;
        REG_ORIGIN_Y: ray_r.org_y    <= cfg_wdata;
        REG_ORIGIN_Z: ray_r.org_z    <= cfg_wdata;
        REG_DIR_X:    ray_r.dir_x    <= cfg_wdata[DIR_W-1:0];
        REG_DIR_Y:    ray_r.dir_y    <= cfg_wdata[DIR_W-1:0];
        REG_DIR_Z:    ray_r.dir_z    <= cfg_wdata[DIR_W-1:0];
        REG_MAX_DIST: ray_r.max_dist <= cfg_wdata[DIST_W-1:0];
        default:      ray_r.max_dist <= ray_r.max_dist;
      endcase
    end
  end

  obrnh_front #(.MAX_BOXES(MAX_BOXES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ray      (ray_r),
    .push     (in_push),
    .center_x (in_box_center_x),
    .center_y (in_box_center_y),
    .center_z (in_box_center_z),
    .rot_x    (in_rot_x),
    .rot_y    (in_rot_y),
    .rot_z    (in_rot_z),
    .rot_w    (in_rot_w),
    .half_x   (in_half_size_x),
    .half_y   (in_half_size_y),
    .half_z   (in_half_size_z),
    .skip     (in_skip_box),
    .last     (in_last_box),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_data   (q_wdata)
  );

  assign in_full = q_full;

  obrnh_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  obrnh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .res_ready (!out_valid_r || out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_hit          = out_r.hit;
  assign out_hit_index    = out_r.idx;
  assign out_hit_distance = out_r.hit_dist;

endmodule

`default_nettype wire

>>> hdl/obrnh_checker.sv
// ----------------------------------------------------------------------------
// obrnh_checker
// Port-level checks of the nearest-hit unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module obrnh_checker
  import obrnh_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_full,
  input wire logic              out_empty,
  input wire logic              out_pop,
  input wire logic              out_hit,
  input wire logic [IDX_W-1:0]  out_hit_index,
  input wire logic [DIST_W-1:0] out_hit_distance
);

  // Reset leaves both queues empty
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_hit) &&
                                  $stable(out_hit_index) && $stable(out_hit_distance)))
    else $error("result changed while waiting");

  // A miss reports zero index and distance
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_hit) |-> (out_hit_index == '0 && out_hit_distance == '0))
    else $error("miss with nonzero payload");

endmodule

bind oriented_box_ray_nearest_hit_unit obrnh_checker u_obrnh_checker (.*);

`default_nettype wire

>>> bench/oriented_box_ray_nearest_hit_unit_test.sv
// ----------------------------------------------------------------------------
// oriented_box_ray_nearest_hit_unit_test
// Self-checking bench for the ray versus oriented box nearest-hit unit.
// Streams of boxes are pushed against several ray settings; a scoreboard
// rotates each box into its own frame, runs the slab test and keeps the
// nearest hit, then compares every popped result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module oriented_box_ray_nearest_hit_unit_test;
  import obrnh_pkg::*;

  // One input beat
  typedef struct {
    logic signed [POSN_W-1:0] cx, cy, cz;
    logic signed [DIR_W-1:0]  qx, qy, qz, qw;
    logic [DIST_W-1:0]        hx, hy, hz;
    logic                     skip, last;
  } box_t;

  // Nearest-hit scoreboard: shadow of the ray registers and the search
  class hit_scoreboard;
    longint ray_org[3];
    longint ray_dir[3];
    longint range_max;
    longint nearest;
    int unsigned nearest_pos;
    bit found;
    int unsigned box_count;
    result_t pending_hits[$];
    int errors;

    function new();
      ray_org = '{0, 0, 0};
      ray_dir = '{16384, 0, 0};
      range_max = 4194304;
      nearest = range_max;
      nearest_pos = 0;
      found = 0;
      box_count = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [POSN_W-1:0] v);
      case (idx)
        REG_ORIGIN_X: ray_org[0] = longint'($signed(v));
        REG_ORIGIN_Y: ray_org[1] = longint'($signed(v));
        REG_ORIGIN_Z: ray_org[2] = longint'($signed(v));
        REG_DIR_X:    ray_dir[0] = longint'($signed(v[DIR_W-1:0]));
        REG_DIR_Y:    ray_dir[1] = longint'($signed(v[DIR_W-1:0]));
        REG_DIR_Z:    ray_dir[2] = longint'($signed(v[DIR_W-1:0]));
        REG_MAX_DIST: range_max  = longint'(v[DIST_W-1:0]);
        default: ;
      endcase
    endfunction

    // Divide by 2^14, nearest, ties away from zero
    function longint shr14_round(longint x);
      longint mag;
      mag = (x < 0) ? -x : x;
      mag = (mag + 8192) >>> 14;
      return (x < 0) ? -mag : mag;
    endfunction

    // Rotate v by quaternion (a, w); quaternion in Q.14
    function void rotate(input longint a[3], input longint w, input longint v[3],
                         output longint o[3]);
      longint c[3];
      c[0] = shr14_round(2 * (a[1] * v[2] - a[2] * v[1]));
      c[1] = shr14_round(2 * (a[2] * v[0] - a[0] * v[2]));
      c[2] = shr14_round(2 * (a[0] * v[1] - a[1] * v[0]));
      o[0] = v[0] + shr14_round(w * c[0] + a[1] * c[2] - a[2] * c[1]);
      o[1] = v[1] + shr14_round(w * c[1] + a[2] * c[0] - a[0] * c[2]);
      o[2] = v[2] + shr14_round(w * c[2] + a[0] * c[1] - a[1] * c[0]);
    endfunction

    // Slab test in the box frame; entry distance clamped at zero
    function bit slab_hit(input longint o[3], input longint d[3], input longint h[3],
                          input longint limit, output longint t_hit);
      longint t_in, t_out, tn, tf, tmp;
      t_in = 0;
      t_out = limit;
      t_hit = 0;
      for (int i = 0; i < 3; i++) begin
        if (d[i] == 0) begin
          // parallel axis: origin must lie inside the slab
          if (o[i] < -h[i] || o[i] > h[i]) return 0;
        end else begin
          tn = ((-h[i] - o[i]) * 16384) / d[i];
          tf = ((h[i] - o[i]) * 16384) / d[i];
          if (tn > tf) begin
            tmp = tn;
            tn = tf;
            tf = tmp;
          end
          if (tn > t_in) t_in = tn;
          if (tf < t_out) t_out = tf;
          if (t_in > t_out) return 0;
        end
      end
      t_hit = t_in;
      return 1;
    endfunction

    // Accepted box: update the search, queue a result on the last box
    function void note_box(box_t b);
      longint a[3], w, off[3], lo[3], ld[3], h[3], t_hit;
      int unsigned pos;
      result_t r;
      if (box_count == 0) begin
        nearest = range_max;
        found = 0;
        nearest_pos = 0;
      end
      pos = box_count;
      if (!b.skip && range_max != 0) begin
        a[0] = -longint'(b.qx);
        a[1] = -longint'(b.qy);
        a[2] = -longint'(b.qz);
        w = longint'(b.qw);
        off[0] = ray_org[0] - longint'(b.cx);
        off[1] = ray_org[1] - longint'(b.cy);
        off[2] = ray_org[2] - longint'(b.cz);
        h[0] = longint'(b.hx);
        h[1] = longint'(b.hy);
        h[2] = longint'(b.hz);
        rotate(a, w, off, lo);
        rotate(a, w, ray_dir, ld);
        if (slab_hit(lo, ld, h, nearest, t_hit) && (!found || t_hit < nearest)) begin
          nearest = t_hit;
          nearest_pos = pos;
          found = 1;
        end
      end
      // position saturates at the top of the counter
      if (box_count < MAX_BOXES_DEF - 1) box_count++;
      if (b.last) begin
        r.hit      = found;
        r.idx      = found ? nearest_pos[IDX_W-1:0] : '0;
        r.hit_dist = found ? nearest[DIST_W-1:0] : '0;
        pending_hits.push_back(r);
        box_count = 0;
        found = 0;
        nearest_pos = 0;
        nearest = range_max;
      end
    endfunction

    function void check_result(logic hit, logic [IDX_W-1:0] idx, logic [DIST_W-1:0] hdist);
      result_t e;
      if (pending_hits.size() == 0) begin
        $error("result beat with nothing expected: hit %0d index %0d distance %0d",
               hit, idx, hdist);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      if (hit !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, hit);
        errors++;
      end
      if (idx !== e.idx) begin
        $error("hit_index: expected %0d, got %0d", e.idx, idx);
        errors++;
      end
      if (hdist !== e.hit_dist) begin
        $error("hit_distance: expected %0d, got %0d", e.hit_dist, hdist);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic signed [POSN_W-1:0] in_box_center_x, in_box_center_y, in_box_center_z;
  logic signed [DIR_W-1:0]  in_rot_x, in_rot_y, in_rot_z, in_rot_w;
  logic [DIST_W-1:0]        in_half_size_x, in_half_size_y, in_half_size_z;
  logic                     in_skip_box, in_last_box;
  logic                     out_empty;
  logic                     out_pop;
  logic                     out_hit;
  logic [IDX_W-1:0]         out_hit_index;
  logic [DIST_W-1:0]        out_hit_distance;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [POSN_W-1:0]        cfg_wdata;

  hit_scoreboard sb = new();
  bit quiet = 0;   // no idling on either side

  oriented_box_ray_nearest_hit_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_box_center_x  (in_box_center_x),
    .in_box_center_y  (in_box_center_y),
    .in_box_center_z  (in_box_center_z),
    .in_rot_x         (in_rot_x),
    .in_rot_y         (in_rot_y),
    .in_rot_z         (in_rot_z),
    .in_rot_w         (in_rot_w),
    .in_half_size_x   (in_half_size_x),
    .in_half_size_y   (in_half_size_y),
    .in_half_size_z   (in_half_size_z),
    .in_skip_box      (in_skip_box),
    .in_last_box      (in_last_box),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_hit          (out_hit),
    .out_hit_index    (out_hit_index),
    .out_hit_distance (out_hit_distance),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("oriented_box_ray_nearest_hit_unit_test NOT OK");
    $finish;
  end

  // Result side: pop with random stall bursts, check each popped beat
  initial begin
    int stall;
    stall = 0;
    out_pop = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall > 0 && !quiet) begin
        out_pop <= 0;
        stall--;
      end else begin
        out_pop <= 1;
        stall = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
      end
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_result(out_hit, out_hit_index, out_hit_distance);
    end
  end

  function automatic box_t mk_box(longint cx, longint cy, longint cz,
                                  int qz, int qw, longint hx, longint hy, longint hz,
                                  bit skip, bit last);
    box_t b;
    b.cx = POSN_W'(cx); b.cy = POSN_W'(cy); b.cz = POSN_W'(cz);
    b.qx = '0; b.qy = '0; b.qz = DIR_W'(qz); b.qw = DIR_W'(qw);
    b.hx = DIST_W'(hx); b.hy = DIST_W'(hy); b.hz = DIST_W'(hz);
    b.skip = skip; b.last = last;
    return b;
  endfunction

  // Push one box, wait for acceptance, then maybe idle
  task automatic send_box(box_t b);
    in_push <= 1;
    in_box_center_x <= b.cx; in_box_center_y <= b.cy; in_box_center_z <= b.cz;
    in_rot_x <= b.qx; in_rot_y <= b.qy; in_rot_z <= b.qz; in_rot_w <= b.qw;
    in_half_size_x <= b.hx; in_half_size_y <= b.hy; in_half_size_z <= b.hz;
    in_skip_box <= b.skip; in_last_box <= b.last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_box(b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_push <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Let every pending result drain, then give the back end time to settle
  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Write all seven ray registers back to back
  task automatic set_ray(longint ox, longint oy, longint oz,
                         longint dx, longint dy, longint dz, longint maxd);
    logic [CFG_IDX_W-1:0] codes[7];
    longint vals[7];
    codes = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z, REG_DIR_X, REG_DIR_Y, REG_DIR_Z,
              REG_MAX_DIST};
    vals = '{ox, oy, oz, dx, dy, dz, maxd};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1;
      cfg_index <= codes[i];
      cfg_wdata <= vals[i][POSN_W-1:0];
      @(posedge clk);
      sb.set_reg(codes[i], vals[i][POSN_W-1:0]);
    end
    cfg_we <= 0;
  endtask

  // Random unit quaternion (or identity)
  function automatic void rand_quat(output logic signed [DIR_W-1:0] q[4]);
    real v[4], n;
    if ($urandom_range(0, 3) == 0) begin
      q = '{0, 0, 0, 16384};
      return;
    end
    n = 0;
    for (int i = 0; i < 4; i++) begin
      v[i] = real'(int'($urandom_range(0, 20000)) - 10000);
      n += v[i] * v[i];
    end
    n = $sqrt(n) + 1.0;
    for (int i = 0; i < 4; i++) q[i] = DIR_W'($rtoi(v[i] * 16384.0 / n));
  endfunction

  // Random ray: axis-aligned unit or random shorter direction, moderate origin, range 16 to 256 units
  task automatic random_ray();
    logic signed [DIR_W-1:0] q[4];
    longint d[3];
    rand_quat(q);
    if ($urandom_range(0, 4) == 0) begin
      d = '{0, 0, 0};
      d[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16384 : -16384;
    end else begin
      d = '{longint'(q[0]), longint'(q[1]), longint'(q[2])};
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) d[0] = 16384;
    end
    set_ray(longint'(int'($urandom_range(0, 1 << 23))) - (1 << 22),
            longint'(int'($urandom_range(0, 1 << 23))) - (1 << 22),
            longint'(int'($urandom_range(0, 1 << 23))) - (1 << 22),
            d[0], d[1], d[2], longint'($urandom_range(16, 256)) << 16);
  endtask

  // Box placed near the ray, or pure noise over the full field ranges
  function automatic box_t random_box(bit last);
    box_t b;
    logic signed [DIR_W-1:0] q[4];
    longint t, c[3];
    if ($urandom_range(0, 6) == 0) begin
      b.cx = $urandom; b.cy = $urandom; b.cz = $urandom;
      b.qx = DIR_W'($urandom); b.qy = DIR_W'($urandom);
      b.qz = DIR_W'($urandom); b.qw = DIR_W'($urandom);
      b.hx = DIST_W'($urandom); b.hy = DIST_W'($urandom); b.hz = DIST_W'($urandom);
    end else begin
      t = $urandom_range(0, 32'(sb.range_max + (sb.range_max >> 3)));
      for (int i = 0; i < 3; i++)
        c[i] = sb.ray_org[i] + ((sb.ray_dir[i] * t) >>> 14)
               + longint'(int'($urandom_range(0, 1 << 19))) - (1 << 18);
      rand_quat(q);
      b.cx = POSN_W'(c[0]); b.cy = POSN_W'(c[1]); b.cz = POSN_W'(c[2]);
      b.qx = q[0]; b.qy = q[1]; b.qz = q[2]; b.qw = q[3];
      b.hx = DIST_W'($urandom_range(6554, 5 << 16));
      b.hy = DIST_W'($urandom_range(6554, 5 << 16));
      b.hz = DIST_W'($urandom_range(6554, 5 << 16));
    end
    b.skip = ($urandom_range(0, 9) == 0);
    b.last = last;
    return b;
  endfunction

  // Random streams of 1 to 12 boxes, ending on a last box
  task automatic random_phase(int count);
    int left;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) left = $urandom_range(1, 12);
      left--;
      send_box(random_box(left == 0 || i == count - 1));
      if (i == count - 1) left = 0;
    end
  endtask

  // Main sequence
  initial begin
    box_t b;
    rst_n = 0;
    in_push = 0;
    in_box_center_x = 0; in_box_center_y = 0; in_box_center_z = 0;
    in_rot_x = 0; in_rot_y = 0; in_rot_z = 0; in_rot_w = 0;
    in_half_size_x = 0; in_half_size_y = 0; in_half_size_z = 0;
    in_skip_box = 0; in_last_box = 0;
    cfg_we = 0; cfg_index = REG_ORIGIN_X; cfg_wdata = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed, reset ray: origin 0, direction +x, range 64
    send_box(mk_box(10 << 16, 0, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 0, 1));
    // miss, far hit, near hit, skipped nearer box, tie, missing last box
    send_box(mk_box(10 << 16, 5 << 16, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 0, 0));
    send_box(mk_box(20 << 16, 0, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 0, 0));
    send_box(mk_box(8 << 16, 0, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 0, 0));
    send_box(mk_box(3 << 16, 0, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 1, 0));
    send_box(mk_box(8 << 16, 0, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 0, 0));
    send_box(mk_box(30 << 16, 9 << 16, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 0, 1));
    // origin inside the box
    send_box(mk_box(0, 0, 0, 0, 16384, 2 << 16, 2 << 16, 2 << 16, 0, 1));
    // entry exactly at the range limit
    send_box(mk_box(65 << 16, 0, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 0, 1));
    // parallel axes, origin outside and then inside the slab
    send_box(mk_box(10 << 16, 3 << 16, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 0, 1));
    send_box(mk_box(10 << 16, 1 << 16, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 0, 1));
    // box turned 90 degrees about z
    send_box(mk_box(12 << 16, 0, 0, 11585, 11585, 3 << 16, 1 << 16, 1 << 16, 0, 1));
    // only skipped boxes: no hit
    send_box(mk_box(5 << 16, 0, 0, 0, 16384, 1 << 16, 1 << 16, 1 << 16, 1, 1));
    // field extremes
    b = mk_box(32'h7fffffff, -32'sh80000000, 32'h7fffffff, -32768, 32767,
               31'h7fffffff, 0, 31'h7fffffff, 0, 0);
    b.qx = DIR_W'(32767); b.qy = DIR_W'(-32768);
    send_box(b);
    b = mk_box(-32'sh80000000, 32'h7fffffff, -32'sh80000000, 32767, -32768,
               0, 31'h7fffffff, 0, 0, 1);
    b.qx = DIR_W'(-32768); b.qy = DIR_W'(32767);
    send_box(b);
    b = mk_box(-1, -1, -1, -1, -1, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0, 1);
    b.qx = DIR_W'(-1); b.qy = DIR_W'(-1);
    send_box(b);
    drain();

    // Register extremes, smallest range; then widest range with new search
    set_ray(32'h7fffffff, -32'sh80000000, 0, -32768, 32767, 0, 1);
    random_phase(6);
    send_box(mk_box(32'h7fffffff, -32'sh80000000, 0, 0, 16384, 4, 4, 4, 0, 1));
    drain();
    set_ray(-32'sh80000000, 32'h7fffffff, -1, 32767, -32768, -32768, 31'h7fffffff);
    random_phase(8);
    drain();

    // Random rays; the last phase runs without idling
    for (int p = 0; p < 6; p++) begin
      random_ray();
      random_phase(90);
      drain();
    end
    quiet = 1;
    random_ray();
    random_phase(80);
    drain();

    if (sb.errors == 0 && sb.pending_hits.size() == 0)
      $display("oriented_box_ray_nearest_hit_unit_test OK");
    else
      $display("oriented_box_ray_nearest_hit_unit_test NOT OK");
    $finish;
  end

endmodule
